/* hdl/piaw_pkg.sv */
package piaw_pkg;

    // field widths
    localparam int TP_W       = 7;
    localparam int KP_W       = 16;
    localparam int KI_W       = 20;
    localparam int SMP_W      = 16;
    localparam int INIT_W     = 7;
    localparam int DUTY_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Q16 percent values
    localparam int INT_W  = 23;
    localparam int Q16_SH = 16;
    localparam logic [INT_W-1:0]  Q16_FULL   = 23'd6553600;
    localparam logic [INT_W-1:0]  ROUND_HALF = 23'd32768;
    localparam logic [TP_W-1:0]   PCT_FULL   = 7'd100;

    // serial multiplier: multiplicand, multiplier and product widths
    localparam int MA_W  = 23;
    localparam int MB_W  = KI_W;
    localparam int PR_W  = MA_W + MB_W;
    // serial divider dividend, counter
    localparam int DVD_W = PR_W;
    localparam int CNT_W = 6;

    // proportional term magnitude and signed sum width
    localparam int P_W  = 29;
    localparam int PS_W = 31;
    localparam logic [PS_W-1:0] Q16_FULL_PS = {{(PS_W-INT_W){1'b0}}, Q16_FULL};

    // register reset values
    localparam logic [TP_W-1:0] TP_RESET = 7'd50;
    localparam logic [KP_W-1:0] KP_RESET = 16'd500;
    localparam logic [KI_W-1:0] KI_RESET = 20'd50000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KI     = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_T_MUL,
        S_T_DIV,
        S_ERR,
        S_E_MUL,
        S_E_DIV,
        S_P_MUL,
        S_P_DIV,
        S_D_MUL,
        S_D_DIV,
        S_INTEG,
        S_OUT
    } t_state;

endpackage

/* hdl/piaw_if.sv */
interface piaw_req_if import piaw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [SMP_W-1:0]  sample_raw;
    logic [INIT_W-1:0] reload_pct;

    modport source (output valid, func, sample_raw, reload_pct, input ready);
    modport sink   (input valid, func, sample_raw, reload_pct, output ready);
endinterface

interface piaw_rsp_if import piaw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_pct;

    modport source (output valid, duty_pct, input ready);
    modport sink   (input valid, duty_pct, output ready);
endinterface

/* hdl/pi_duty_controller_antiwindup_top.sv */
// pi duty controller with conditional-integration anti-windup
// i_req carries one request: func 0 is a control step with an adc sample,
// func 1 reloads the integrator from reload_pct and gives no result.
// o_rsp carries the duty cycle in percent, 0..100, one for each control step.
// gains and setpoint are written through i_cfg_we / i_cfg_idx / i_cfg_data
// while no request is in flight; a setpoint above 100 is stored as 100.
// a control step runs through one shift-add multiplier and one restoring
// divider, both one bit per cycle, four multiply/divide pairs in a row;
// i_req.ready rises together with o_rsp.valid, so the next request can be
// taken as soon as the result is shown.
// a reload request loads the integrator and leaves the block idle.
// the result sits in an output register, so the next request is accepted while
// it waits; a control step that finishes while the receiver still stalls the
// previous result holds in its last state until that result is taken.
// reset (synchronous, active low) clears the integrator, restores the register
// defaults and drops o_rsp.valid.
module pi_duty_controller_antiwindup_top import piaw_pkg::*; #(
    parameter int unsigned ADC_MAX     = 4095,
    parameter int unsigned SAMPLE_RATE = 10000
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    piaw_req_if.sink              i_req,
    piaw_rsp_if.source            o_rsp
);

    localparam int ERR_W = $clog2(ADC_MAX + 1);
    localparam int DD_W  = $clog2(64'd1000 * SAMPLE_RATE + 64'd1);
    localparam int DVS_W = (DD_W > ERR_W) ? DD_W : ERR_W;

    // bit counts of each multiplier and divider run
    localparam int N_TM = TP_W;
    localparam int N_TD = TP_W + ERR_W;
    localparam int N_EM = ERR_W;
    localparam int N_ED = ERR_W + MA_W;
    localparam int N_PM = KP_W;
    localparam int N_PD = MA_W + KP_W;
    localparam int N_DM = KI_W;
    localparam int N_DD = MA_W + KI_W;

    // product alignment and dividend left-justify amounts
    localparam int SH_TM = MB_W - N_TM;
    localparam int SH_EM = MB_W - N_EM;
    localparam int SH_PM = MB_W - N_PM;
    localparam int SH_DM = MB_W - N_DM;
    localparam int SL_TD = DVD_W - N_TD;
    localparam int SL_ED = DVD_W - N_ED;
    localparam int SL_PD = DVD_W - N_PD;
    localparam int SL_DD = DVD_W - N_DD;

    localparam logic [DVS_W-1:0] DV_T = DVS_W'(100);
    localparam logic [DVS_W-1:0] DV_E = DVS_W'(ADC_MAX);
    localparam logic [DVS_W-1:0] DV_P = DVS_W'(1000);
    localparam logic [DVS_W-1:0] DV_D = DVS_W'(64'd1000 * SAMPLE_RATE);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [MA_W-1:0]    r_ma, n_ma;
    logic [MB_W-1:0]    r_mb, n_mb;
    logic [MA_W-1:0]    r_mhi, n_mhi;
    logic [DVD_W-1:0]   r_dvd, n_dvd;
    logic [DVS_W-1:0]   r_rem, n_rem;
    logic [DVS_W-1:0]   r_dvs, n_dvs;
    logic [ERR_W-1:0]   r_smp, n_smp;
    logic [ERR_W-1:0]   r_tgt, n_tgt;
    logic               r_neg, n_neg;
    logic [MA_W-1:0]    r_e, n_e;
    logic [P_W-1:0]     r_pm, n_pm;
    logic [INT_W-1:0]   r_integ, n_integ;
    logic               r_ovalid, n_ovalid;
    logic [DUTY_W-1:0]  r_oduty, n_oduty;
    logic [TP_W-1:0]    r_tp;
    logic [KP_W-1:0]    r_kp;
    logic [KI_W-1:0]    r_ki;

    logic [MA_W:0]      w_madd;
    logic [MA_W-1:0]    w_mhi_step;
    logic [MB_W-1:0]    w_mb_step;
    logic [PR_W-1:0]    w_prod;
    logic [DVS_W:0]     w_rsh;
    logic [DVS_W:0]     w_rsub;
    logic               w_qb;
    logic [DVS_W-1:0]   w_rem_step;
    logic [DVD_W-1:0]   w_dvd_step;
    logic [ERR_W:0]     w_err;
    logic [ERR_W:0]     w_emag;
    logic [TP_W-1:0]    w_init;
    logic [ERR_W-1:0]   w_smp_sat;
    logic [PS_W-1:0]    w_pext;
    logic [PS_W-1:0]    w_p;
    logic [PS_W-1:0]    w_isum;
    logic               w_isum_neg;
    logic               w_dnz;
    logic               w_skip;
    logic [DVD_W-1:0]   w_iup;
    logic [INT_W-1:0]   w_inew;
    logic [INT_W-1:0]   w_osat;
    logic [INT_W-1:0]   w_round;

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_ovalid;
    assign o_rsp.duty_pct = r_oduty;

    // one multiplier bit per cycle, product shifts in from the top
    assign w_madd     = r_mb[0] ? ({1'b0, r_mhi} + {1'b0, r_ma}) : {1'b0, r_mhi};
    assign w_mhi_step = w_madd[MA_W:1];
    assign w_mb_step  = {w_madd[0], r_mb[MB_W-1:1]};
    assign w_prod     = {w_mhi_step, w_mb_step};

    // restoring divide, quotient bits shift into the dividend register
    assign w_rsh      = {r_rem, r_dvd[DVD_W-1]};
    assign w_rsub     = w_rsh - {1'b0, r_dvs};
    assign w_qb       = (w_rsh >= {1'b0, r_dvs});
    assign w_rem_step = w_qb ? w_rsub[DVS_W-1:0] : w_rsh[DVS_W-1:0];
    assign w_dvd_step = {r_dvd[DVD_W-2:0], w_qb};

    assign w_init    = (i_req.reload_pct > PCT_FULL) ? PCT_FULL : i_req.reload_pct;
    assign w_smp_sat = (i_req.sample_raw > SMP_W'(ADC_MAX)) ? ERR_W'(ADC_MAX)
                                                            : i_req.sample_raw[ERR_W-1:0];

    assign w_err  = {1'b0, r_tgt} - {1'b0, r_smp};
    assign w_emag = w_err[ERR_W] ? ({(ERR_W+1){1'b0}} - w_err) : w_err;

    // signed p plus integrator, read before and after the integrator update
    assign w_pext     = {{(PS_W-P_W){1'b0}}, r_pm};
    assign w_p        = r_neg ? ({PS_W{1'b0}} - w_pext) : w_pext;
    assign w_isum     = w_p + {{(PS_W-INT_W){1'b0}}, r_integ};
    assign w_isum_neg = w_isum[PS_W-1];
    assign w_dnz      = |r_dvd;
    assign w_skip     = (!r_neg && w_dnz && !w_isum_neg && (w_isum >= Q16_FULL_PS))
                     || (r_neg && w_dnz && (w_isum_neg || (w_isum == '0)));

    assign w_iup  = {{(DVD_W-INT_W){1'b0}}, r_integ} + r_dvd;
    assign w_inew = r_neg
        ? ((r_dvd > {{(DVD_W-INT_W){1'b0}}, r_integ}) ? '0 : r_integ - r_dvd[INT_W-1:0])
        : ((w_iup > {{(DVD_W-INT_W){1'b0}}, Q16_FULL}) ? Q16_FULL : w_iup[INT_W-1:0]);

    assign w_osat  = w_isum_neg ? '0
                   : ((w_isum > Q16_FULL_PS) ? Q16_FULL : w_isum[INT_W-1:0]);
    assign w_round = w_osat + ROUND_HALF;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_mhi    = r_mhi;
        n_dvd    = r_dvd;
        n_rem    = r_rem;
        n_dvs    = r_dvs;
        n_smp    = r_smp;
        n_tgt    = r_tgt;
        n_neg    = r_neg;
        n_e      = r_e;
        n_pm     = r_pm;
        n_integ  = r_integ;
        n_ovalid = r_ovalid && !o_rsp.ready;
        n_oduty  = r_oduty;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.func) begin
                        n_integ = {w_init, {Q16_SH{1'b0}}};
                    end else begin
                        n_smp   = w_smp_sat;
                        n_ma    = MA_W'(ADC_MAX);
                        n_mb    = MB_W'(r_tp);
                        n_mhi   = '0;
                        n_cnt   = CNT_W'(N_TM - 1);
                        n_state = S_T_MUL;
                    end
                end
            end
            S_T_MUL: begin
                n_mhi = w_mhi_step;
                n_mb  = w_mb_step;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_dvd   = (w_prod >> SH_TM) << SL_TD;
                    n_rem   = '0;
                    n_dvs   = DV_T;
                    n_cnt   = CNT_W'(N_TD - 1);
                    n_state = S_T_DIV;
                end
            end
            S_T_DIV: begin
                n_dvd = w_dvd_step;
                n_rem = w_rem_step;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_tgt   = w_dvd_step[ERR_W-1:0];
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                n_neg   = w_err[ERR_W];
                n_ma    = Q16_FULL;
                n_mb    = MB_W'(w_emag[ERR_W-1:0]);
                n_mhi   = '0;
                n_cnt   = CNT_W'(N_EM - 1);
                n_state = S_E_MUL;
            end
            S_E_MUL: begin
                n_mhi = w_mhi_step;
                n_mb  = w_mb_step;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_dvd   = (w_prod >> SH_EM) << SL_ED;
                    n_rem   = '0;
                    n_dvs   = DV_E;
                    n_cnt   = CNT_W'(N_ED - 1);
                    n_state = S_E_DIV;
                end
            end
            S_E_DIV: begin
                n_dvd = w_dvd_step;
                n_rem = w_rem_step;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_e     = w_dvd_step[MA_W-1:0];
                    n_ma    = w_dvd_step[MA_W-1:0];
                    n_mb    = MB_W'(r_kp);
                    n_mhi   = '0;
                    n_cnt   = CNT_W'(N_PM - 1);
                    n_state = S_P_MUL;
                end
            end
            S_P_MUL: begin
                n_mhi = w_mhi_step;
                n_mb  = w_mb_step;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_dvd   = (w_prod >> SH_PM) << SL_PD;
                    n_rem   = '0;
                    n_dvs   = DV_P;
                    n_cnt   = CNT_W'(N_PD - 1);
                    n_state = S_P_DIV;
                end
            end
            S_P_DIV: begin
                n_dvd = w_dvd_step;
                n_rem = w_rem_step;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_pm    = w_dvd_step[P_W-1:0];
                    n_ma    = r_e;
                    n_mb    = r_ki;
                    n_mhi   = '0;
                    n_cnt   = CNT_W'(N_DM - 1);
                    n_state = S_D_MUL;
                end
            end
            S_D_MUL: begin
                n_mhi = w_mhi_step;
                n_mb  = w_mb_step;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_dvd   = (w_prod >> SH_DM) << SL_DD;
                    n_rem   = '0;
                    n_dvs   = DV_D;
                    n_cnt   = CNT_W'(N_DD - 1);
                    n_state = S_D_DIV;
                end
            end
            S_D_DIV: begin
                n_dvd = w_dvd_step;
                n_rem = w_rem_step;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_INTEG;
                end
            end
            S_INTEG: begin
                // integrator step magnitude is left in the divider register
                if (!w_skip) begin
                    n_integ = w_inew;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_oduty  = w_round[Q16_SH+DUTY_W-1:Q16_SH];
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_integ  <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_integ  <= n_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_mhi   <= n_mhi;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_dvs   <= n_dvs;
        r_smp   <= n_smp;
        r_tgt   <= n_tgt;
        r_neg   <= n_neg;
        r_e     <= n_e;
        r_pm    <= n_pm;
        r_oduty <= n_oduty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tp <= TP_RESET;
            r_kp <= KP_RESET;
            r_ki <= KI_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET: begin
                    r_tp <= (i_cfg_data[TP_W-1:0] > PCT_FULL) ? PCT_FULL
                                                              : i_cfg_data[TP_W-1:0];
                end
                CFG_KP: begin
                    r_kp <= i_cfg_data[KP_W-1:0];
                end
                CFG_KI: begin
                    r_ki <= i_cfg_data[KI_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* hdl/piaw_checker.sv */
module piaw_checker import piaw_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    piaw_req_if.sink   i_req,
    piaw_rsp_if.source i_rsp
);

    // a stalled result keeps its value
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp.valid && !i_rsp.ready |=> i_rsp.valid && $stable(i_rsp.duty_pct))
        else $error("result changed or dropped while stalled");

    // duty never leaves 0..100
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp.valid |-> i_rsp.duty_pct <= PCT_FULL)
        else $error("duty above full scale");

    // no result can follow a request in the very next cycle
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && !i_rsp.valid |=> !i_rsp.valid)
        else $error("result appeared right after a request");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp.valid)
        else $error("result valid after reset");

endmodule

bind pi_duty_controller_antiwindup_top piaw_checker u_piaw_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_req   (i_req),
    .i_rsp   (o_rsp)
);
